### hdl/wes_pkg.sv
// Shared types, constants and helpers for the weighted event selector.
package wes_pkg;

  // Table geometry and field widths
  localparam int MAX_ENTRIES = 64;
  localparam int WEIGHT_BITS = 16;
  localparam int WEIGHT_W    = 16;
  localparam int SUM_W       = 22;
  localparam int INDEX_W     = 6;
  localparam int STATUS_W    = 2;

  // Weight bits actually used: the port carries at most 16
  localparam int WEIGHT_EFF  = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK =
    WEIGHT_W'((33'd1 << WEIGHT_EFF) - 33'd1);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Each cell holds eight consecutive entries
  localparam int SLOT_W    = 3;
  localparam int SLOTS     = 1 << SLOT_W;
  localparam int NUM_CELLS = (MAX_ENTRIES + SLOTS - 1) / SLOTS;
  localparam int CELL_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int POS_W     = CELL_W + SLOT_W;
  localparam int COUNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W     = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  // Command and status codes
  localparam logic CMD_APPEND = 1'b0;
  localparam logic [STATUS_W-1:0] STATUS_FOUND   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CLAMPED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [CMP_W-1:0]   cmp_t;

  typedef struct packed {
    logic                command;
    logic                first;
    logic [WEIGHT_W-1:0] weight;
    logic [SUM_W-1:0]    draw;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  event_index;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Search token walking down the cell chain
  typedef struct packed {
    logic valid;
    logic found;
    pos_t pos;
  } token_t;

  // Append write broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] cell_sel;
    logic [SLOT_W-1:0] slot;
    sum_t              data;
  } wr_t;

  // Search operands, held steady while a token is in flight
  typedef struct packed {
    sum_t   draw;
    count_t count;
  } query_t;

  function automatic cmp_t pos_to_cmp(input pos_t p);
    return cmp_t'(p);
  endfunction

  function automatic cmp_t count_to_cmp(input count_t c);
    return cmp_t'(c);
  endfunction

  // Low INDEX_W bits of a table position, zero-extended if narrower
  function automatic logic [INDEX_W-1:0] fit_index(input cmp_t v);
    logic [CMP_W+INDEX_W-1:0] w;
    w = {{INDEX_W{1'b0}}, v};
    return w[INDEX_W-1:0];
  endfunction

endpackage

### hdl/wes_if.sv
// Valid/ready channel interfaces for input items and result words.
interface wes_item_if;
  import wes_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wes_result_if;
  import wes_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hdl/weighted_event_selector.sv
// Append: no result word; the next item is taken on the following cycle.
// Select: the search token walks through NUM_CELLS cells of eight entries, one cell a cycle;
//   the result is registered in a hold state, then loaded onto the output word.
// Select on an empty table: no search, an EMPTY result word. One item is worked on at a time.
// Reset (synchronous): table empty, running total zero, no word pending; table
//   entries are not cleared and are only read below the entry count.
module weighted_event_selector (
  input  logic         clk,
  input  logic         rst,
  wes_item_if.sink     items,
  wes_result_if.source results
);
  import wes_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_BUSY, S_HOLD} state_t;

  state_t  state;
  count_t  entry_count;
  sum_t    running_total;
  logic    start_valid;
  query_t  query;
  result_t pend;
  result_t out_data;
  logic    out_valid;

  logic    item_acc;
  logic    launch;
  logic    load_out;
  count_t  base_count;
  sum_t    base_total;
  logic    full;
  logic [SUM_W:0] sum_wide;
  sum_t    new_total;
  cmp_t    base_pos;
  cmp_t    last_pos;
  wr_t     wr;
  token_t  tok [NUM_CELLS+1];

  assign items.ready   = (state == S_IDLE);
  assign item_acc      = items.valid && items.ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  // Search start on a select into a non-empty table; output load from hold
  assign launch   = item_acc && (items.data.command != CMD_APPEND) &&
                    (entry_count != '0);
  assign load_out = (state == S_HOLD) && (!out_valid || results.ready);

  // Append datapath: new table or continue, saturating running sum
  always_comb begin
    base_count = items.data.first ? '0 : entry_count;
    base_total = items.data.first ? '0 : running_total;
    full       = (base_count >= count_t'(MAX_ENTRIES));
    sum_wide   = {1'b0, base_total} + (SUM_W+1)'(items.data.weight & WEIGHT_MASK);
    new_total  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    base_pos   = count_to_cmp(base_count);
    last_pos   = count_to_cmp(entry_count) - cmp_t'(1);
  end

  assign wr.en       = item_acc && (items.data.command == CMD_APPEND) && !full;
  assign wr.cell_sel = base_pos[POS_W-1:SLOT_W];
  assign wr.slot     = base_pos[SLOT_W-1:0];
  assign wr.data     = new_total;

  // Cell chain
  assign tok[0] = '{valid: start_valid, found: 1'b0, pos: '0};

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    wes_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cell_id (CELL_W'(i)),
      .wr      (wr),
      .query   (query),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  // Control: table state, search launch, result hold and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      entry_count   <= '0;
      running_total <= '0;
      start_valid   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      start_valid <= launch;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            if (items.data.command == CMD_APPEND) begin
              if (!full) begin
                entry_count   <= base_count + count_t'(1);
                running_total <= new_total;
              end
            end else if (entry_count == '0) begin
              pend  <= '{event_index: '0, status: STATUS_EMPTY};
              state <= S_HOLD;
            end else begin
              query.draw  <= items.data.draw;
              query.count <= entry_count;
              state       <= S_BUSY;
            end
          end
        end
        S_BUSY: begin
          if (tok[NUM_CELLS].valid) begin
            if (tok[NUM_CELLS].found) begin
              pend <= '{event_index: fit_index(pos_to_cmp(tok[NUM_CELLS].pos)),
                        status: STATUS_FOUND};
            end else begin
              pend <= '{event_index: fit_index(last_pos), status: STATUS_CLAMPED};
            end
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load_out) begin
            out_data <= pend;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A token leaves the chain only while a search is in flight
  a_tail_busy: assert property (@(posedge clk) disable iff (rst)
    tok[NUM_CELLS].valid |-> (state == S_BUSY))
    else $error("search token left chain outside a search");

  // Entry count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    entry_count <= count_t'(MAX_ENTRIES))
    else $error("entry count beyond capacity");

  // A found position lies inside the current table
  a_found_inside: assert property (@(posedge clk) disable iff (rst)
    (tok[NUM_CELLS].valid && tok[NUM_CELLS].found) |->
      (pos_to_cmp(tok[NUM_CELLS].pos) < count_to_cmp(entry_count)))
    else $error("found position outside table");

endmodule

### hdl/wes_cell.sv
// One chain cell: eight cumulative-sum entries and one stage of the search token.
module wes_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [wes_pkg::CELL_W-1:0] cell_id,
  input  wes_pkg::wr_t              wr,
  input  wes_pkg::query_t           query,
  input  wes_pkg::token_t           tok_in,
  output wes_pkg::token_t           tok_out
);
  import wes_pkg::*;

  sum_t              entry [SLOTS];
  logic [SLOTS-1:0]  hit;
  logic              hit_any;
  logic [SLOT_W-1:0] first_slot;

  // Entry write on append
  always_ff @(posedge clk) begin
    if (wr.en && (wr.cell_sel == cell_id)) begin
      entry[wr.slot] <= wr.data;
    end
  end

  // Per-slot test: entry is in the table and above the draw
  for (genvar j = 0; j < SLOTS; j++) begin : g_slot
    pos_t slot_pos;
    assign slot_pos = {cell_id, SLOT_W'(j)};
    assign hit[j]   = (pos_to_cmp(slot_pos) < count_to_cmp(query.count)) &&
                      (entry[j] > query.draw);
  end

  // Lowest hitting slot
  always_comb begin
    hit_any    = |hit;
    first_slot = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        first_slot = SLOT_W'(j);
      end
    end
  end

  // Token stage: first cell with a hit claims the position
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.found <= tok_in.found | hit_any;
    if (!tok_in.found && hit_any) begin
      tok_out.pos <= {cell_id, first_slot};
    end else begin
      tok_out.pos <= tok_in.pos;
    end
  end

endmodule
